// File: hdl/bwmf_pkg.sv
// Shared types and constants for the blitter word datapath.
package bwmf_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMinterm   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAShift    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBShift    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDesc      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFillMode  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFillCin   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFirstMask = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLastMask  = 3'd7;

  // Fill mode codes; bit 0 selects inclusive fill
  localparam logic [1:0] FillNone = 2'd0;
  localparam logic [1:0] FillIncl = 2'd1;
  localparam logic [1:0] FillExcl = 2'd2;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [7:0] minterm_function;
    logic [3:0] a_shift_amount;
    logic [3:0] b_shift_amount;
    logic       descending_mode;
    logic [1:0] fill_mode;
    logic       fill_carry_in;
    word_t      first_word_mask;
    word_t      last_word_mask;
  } cfg_t;

  typedef struct packed {
    word_t a_word;
    word_t b_word;
    word_t c_word;
    logic  blit_start;
    logic  row_first;
    logic  row_last;
  } item_t;

  // Carried state between words
  typedef struct packed {
    word_t prior_a;
    word_t prior_b;
    logic  fill_carry;
  } hist_t;

endpackage

// File: hdl/bwmf_datapath.sv
// Combinational word datapath: mask, shift, minterm and area fill.
module bwmf_datapath (
  input  bwmf_pkg::cfg_t  cfg,
  input  bwmf_pkg::item_t item,
  input  bwmf_pkg::hist_t hist,
  output bwmf_pkg::word_t d_word,
  output bwmf_pkg::hist_t hist_nxt
);

  bwmf_pkg::word_t a_m;
  bwmf_pkg::word_t prev_a;
  bwmf_pkg::word_t prev_b;
  bwmf_pkg::word_t a_sh;
  bwmf_pkg::word_t b_sh;
  bwmf_pkg::word_t mt;
  bwmf_pkg::word_t filled;
  bwmf_pkg::word_t carry_at;
  logic [2*bwmf_pkg::WordW-1:0] a_pair;
  logic [2*bwmf_pkg::WordW-1:0] b_pair;
  logic carry0;
  logic fill_on;
  logic incl;

  always_comb begin
    a_m = item.a_word;
    if (item.row_first) begin
      a_m = a_m & cfg.first_word_mask;
    end
    if (item.row_last) begin
      a_m = a_m & cfg.last_word_mask;
    end
    prev_a = item.blit_start ? '0 : hist.prior_a;
    prev_b = item.blit_start ? '0 : hist.prior_b;
  end

  // Descending: current word sits high and bits move up; take the upper half.
  always_comb begin
    if (cfg.descending_mode) begin
      a_pair = {a_m, prev_a} << cfg.a_shift_amount;
      b_pair = {item.b_word, prev_b} << cfg.b_shift_amount;
      a_sh   = a_pair[2*bwmf_pkg::WordW-1:bwmf_pkg::WordW];
      b_sh   = b_pair[2*bwmf_pkg::WordW-1:bwmf_pkg::WordW];
    end else begin
      a_pair = {prev_a, a_m} >> cfg.a_shift_amount;
      b_pair = {prev_b, item.b_word} >> cfg.b_shift_amount;
      a_sh   = a_pair[bwmf_pkg::WordW-1:0];
      b_sh   = b_pair[bwmf_pkg::WordW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < bwmf_pkg::WordW; i++) begin
      mt[i] = cfg.minterm_function[{a_sh[i], b_sh[i], item.c_word[i]}];
    end
  end

  // Fill carry into bit i is the starting carry XOR all minterm bits below i.
  assign carry0  = item.row_first ? cfg.fill_carry_in : hist.fill_carry;
  assign fill_on = (cfg.fill_mode != bwmf_pkg::FillNone);
  assign incl    = cfg.fill_mode[0];

  always_comb begin
    for (int i = 0; i < bwmf_pkg::WordW; i++) begin
      carry_at[i] = carry0 ^ (^(mt & ((bwmf_pkg::WordW)'(1) << i) - (bwmf_pkg::WordW)'(1)));
      if (carry_at[i]) begin
        filled[i] = incl ? 1'b1 : ~mt[i];
      end else begin
        filled[i] = mt[i];
      end
    end
  end

  assign d_word              = fill_on ? filled : mt;
  assign hist_nxt.prior_a    = a_m;
  assign hist_nxt.prior_b    = item.b_word;
  assign hist_nxt.fill_carry = fill_on ? (carry0 ^ (^mt)) : carry0;

endmodule

// File: hdl/blit_word_minterm_fill.sv
// Top level of the blitter word datapath: input register, datapath, output register.
//
//   channel | dir | payload
//   in_     | in  | tdata {c_word, b_word, a_word}, tuser {row_first, blit_start}, tlast row_last
//   out_    | out | tdata d_word, tlast end_of_row
//   cfg_    | in  | cfg_index selects register, cfg_data written when cfg_wr_en
//
// One word per cycle while out_tready is high; out_tvalid comes from the output register.
// The datapath sits between the input register and the output register, and the
// prior A/B words and fill carry update as a word moves between the two.
// rst_n is synchronous, active low; it empties both stages, clears history and resets config.
// A stalled output holds; the input register still takes one more word.
module blit_word_minterm_fill (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // a_word[15:0], b_word[31:16], c_word[47:32]
  input  logic [1:0]  in_tuser,   // blit_start[0], row_first[1]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // d_word[15:0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bwmf_pkg::cfg_t  cfg_r;
  bwmf_pkg::item_t item_r;
  bwmf_pkg::hist_t hist_r;
  bwmf_pkg::hist_t hist_nxt;
  bwmf_pkg::word_t d_word;
  bwmf_pkg::word_t d_r;
  logic            last_r;
  logic            in_valid_r;
  logic            out_valid_r;
  logic            advance;
  logic            in_take;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.minterm_function <= '0;
      cfg_r.a_shift_amount   <= '0;
      cfg_r.b_shift_amount   <= '0;
      cfg_r.descending_mode  <= 1'b0;
      cfg_r.fill_mode        <= bwmf_pkg::FillNone;
      cfg_r.fill_carry_in    <= 1'b0;
      cfg_r.first_word_mask  <= '1;
      cfg_r.last_word_mask   <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bwmf_pkg::RegMinterm:   cfg_r.minterm_function <= cfg_data[7:0];
        bwmf_pkg::RegAShift:    cfg_r.a_shift_amount   <= cfg_data[3:0];
        bwmf_pkg::RegBShift:    cfg_r.b_shift_amount   <= cfg_data[3:0];
        bwmf_pkg::RegDesc:      cfg_r.descending_mode  <= cfg_data[0];
        bwmf_pkg::RegFillMode:  cfg_r.fill_mode        <= cfg_data[1:0];
        bwmf_pkg::RegFillCin:   cfg_r.fill_carry_in    <= cfg_data[0];
        bwmf_pkg::RegFirstMask: cfg_r.first_word_mask  <= cfg_data;
        bwmf_pkg::RegLastMask:  cfg_r.last_word_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r      <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        hist_r      <= hist_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.a_word     <= in_tdata[15:0];
      item_r.b_word     <= in_tdata[31:16];
      item_r.c_word     <= in_tdata[47:32];
      item_r.blit_start <= in_tuser[0];
      item_r.row_first  <= in_tuser[1];
      item_r.row_last   <= in_tlast;
    end
    if (advance) begin
      d_r    <= d_word;
      last_r <= item_r.row_last;
    end
  end

  bwmf_datapath u_dp (
    .cfg      (cfg_r),
    .item     (item_r),
    .hist     (hist_r),
    .d_word   (d_word),
    .hist_nxt (hist_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = d_r;
  assign out_tlast  = last_r;

endmodule

// File: hdl/bwmf_checker.sv
// Port-level checks for the blitter word datapath, bound to the top level.
module bwmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // A stalled output word holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Both stages empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // A consumer taking words never backs up the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // Input can only stall behind a waiting output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with output stage free");

endmodule

bind blit_word_minterm_fill bwmf_checker u_bwmf_checker (.*);

// File: bench/tb_blit_word_minterm_fill.sv
// Self-checking bench for the blitter word datapath: directed table, then random blits.
module tb_blit_word_minterm_fill;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 1000;
  localparam int PhaseCount = 12;
  localparam int PhaseWords = 77;

  typedef struct packed {
    bwmf_pkg::word_t d_word;
    logic            end_of_row;
  } dest_t;

  typedef enum logic [1:0] {RowCfg, RowWord, RowPinned} row_kind_e;

  // flags: {blit_start, row_first, row_last}; value is register data or pinned d_word
  typedef struct packed {
    row_kind_e       kind;
    logic [2:0]      cfg_sel;
    bwmf_pkg::word_t a_word;
    bwmf_pkg::word_t b_word;
    bwmf_pkg::word_t c_word;
    logic [2:0]      flags;
    bwmf_pkg::word_t value;
  } row_t;

  localparam row_t Plan [47] = '{
    '{RowPinned, bwmf_pkg::RegMinterm, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 16'h0000},
    '{RowCfg, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h00FF},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'hFFFF},
    '{RowCfg, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h00F0},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'h1234, 16'hFFFF, 16'h0000, 3'b110, 16'h1234},
    '{RowCfg, bwmf_pkg::RegFirstMask, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h00FF},
    '{RowCfg, bwmf_pkg::RegLastMask, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'hFF00},
    // single-word row: both masks
    '{RowPinned, bwmf_pkg::RegMinterm, 16'hFFFF, 16'h0000, 16'h0000, 3'b011, 16'h0000},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'hFFFF, 16'h0000, 16'h0000, 3'b010, 16'h00FF},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'hFFFF, 16'h0000, 16'h0000, 3'b001, 16'hFF00},
    '{RowCfg, bwmf_pkg::RegFirstMask, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h0000},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'hFFFF, 16'h0000, 16'h0000, 3'b110, 16'h0000},
    '{RowCfg, bwmf_pkg::RegFirstMask, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'hFFFF},
    '{RowCfg, bwmf_pkg::RegLastMask, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'hFFFF},
    '{RowCfg, bwmf_pkg::RegAShift, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h000F},
    // blit start inside a row, then the prior word shifts in
    '{RowPinned, bwmf_pkg::RegMinterm, 16'hFFFF, 16'h0000, 16'h0000, 3'b100, 16'h0001},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'hFFFE},
    '{RowCfg, bwmf_pkg::RegDesc, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h0001},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'h0001, 16'h0000, 16'h0000, 3'b100, 16'h8000},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h8421, 16'h0000, 16'h0000, 3'b000, 16'h0000},
    '{RowCfg, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h00CC},
    '{RowCfg, bwmf_pkg::RegBShift, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h0007},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'hABCD, 16'h0000, 3'b110, 16'h0000},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'h5A5A, 16'h0000, 3'b001, 16'h0000},
    '{RowCfg, bwmf_pkg::RegDesc, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h0000},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'hF00F, 16'h0000, 3'b000, 16'h0000},
    '{RowCfg, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h00AA},
    '{RowCfg, bwmf_pkg::RegFillMode, 16'h0000, 16'h0000, 16'h0000, 3'b000,
      16'(bwmf_pkg::FillIncl)},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0001, 3'b010, 16'hFFFF},
    '{RowCfg, bwmf_pkg::RegFillMode, 16'h0000, 16'h0000, 16'h0000, 3'b000,
      16'(bwmf_pkg::FillExcl)},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h8001, 3'b010, 16'h7FFF},
    '{RowCfg, bwmf_pkg::RegFillCin, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h0001},
    '{RowPinned, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b010, 16'hFFFF},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0F00, 3'b000, 16'h0000},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h1234, 3'b001, 16'h0000},
    // fill mode three behaves as inclusive
    '{RowCfg, bwmf_pkg::RegFillMode, 16'h0000, 16'h0000, 16'h0000, 3'b000,
      16'(bwmf_pkg::FillIncl | bwmf_pkg::FillExcl)},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h00F0, 3'b010, 16'h0000},
    // carry must survive a word with fill off
    '{RowCfg, bwmf_pkg::RegFillMode, 16'h0000, 16'h0000, 16'h0000, 3'b000,
      16'(bwmf_pkg::FillNone)},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0101, 3'b000, 16'h0000},
    '{RowCfg, bwmf_pkg::RegFillMode, 16'h0000, 16'h0000, 16'h0000, 3'b000,
      16'(bwmf_pkg::FillIncl)},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b001, 16'h0000},
    '{RowCfg, bwmf_pkg::RegMinterm, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h00E8},
    '{RowCfg, bwmf_pkg::RegAShift, 16'h0000, 16'h0000, 16'h0000, 3'b000, 16'h0005},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h1357, 16'h9BDF, 16'h2468, 3'b110, 16'h0000},
    '{RowWord, bwmf_pkg::RegMinterm, 16'hFFFF, 16'h0000, 16'hAAAA, 3'b000, 16'h0000},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h0000, 16'hFFFF, 16'h5555, 3'b001, 16'h0000},
    '{RowWord, bwmf_pkg::RegMinterm, 16'h7777, 16'h8888, 16'hCCCC, 3'b011, 16'h0000}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // a_word[15:0], b_word[31:16], c_word[47:32]
  logic [1:0]  in_tuser;   // blit_start[0], row_first[1]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // d_word[15:0]
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  bwmf_pkg::cfg_t  cfg_now;
  bwmf_pkg::hist_t hist_now;
  dest_t pending_dest[$];
  int    fails = 0;
  int    quiet = 0;
  int    hold_req = 0;
  bit    tx_idle_en = 1'b1;
  bit    rx_idle_en = 1'b1;
  bit    cfg_open = 1'b0;

  blit_word_minterm_fill dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Two-word funnel shift: ascending takes {prev, cur} rightward, descending {cur, prev} leftward
  function automatic bwmf_pkg::word_t funnel(input bwmf_pkg::word_t cur,
                                             input bwmf_pkg::word_t prev,
                                             input logic [3:0] sh, input logic desc);
    logic [31:0] pair;
    if (desc) begin
      pair = {cur, prev} << sh;
      return pair[31:16];
    end
    pair = {prev, cur} >> sh;
    return pair[15:0];
  endfunction

  function automatic dest_t blit_dest(input bwmf_pkg::item_t w);
    bwmf_pkg::word_t am, sa, sb, d, src;
    logic  carry;
    dest_t r;
    if (w.blit_start) begin
      hist_now.prior_a = '0;
      hist_now.prior_b = '0;
    end
    if (w.row_first) hist_now.fill_carry = cfg_now.fill_carry_in;
    am = w.a_word;
    if (w.row_first) am &= cfg_now.first_word_mask;
    if (w.row_last) am &= cfg_now.last_word_mask;
    sa = funnel(am, hist_now.prior_a, cfg_now.a_shift_amount, cfg_now.descending_mode);
    sb = funnel(w.b_word, hist_now.prior_b, cfg_now.b_shift_amount, cfg_now.descending_mode);
    hist_now.prior_a = am;
    hist_now.prior_b = w.b_word;
    for (int i = 0; i < bwmf_pkg::WordW; i++)
      d[i] = cfg_now.minterm_function[{sa[i], sb[i], w.c_word[i]}];
    if (cfg_now.fill_mode != bwmf_pkg::FillNone) begin
      carry = hist_now.fill_carry;
      src = d;
      for (int i = 0; i < bwmf_pkg::WordW; i++) begin
        if (carry) d[i] = ((cfg_now.fill_mode & bwmf_pkg::FillIncl) != 0) ? 1'b1 : ~d[i];
        carry ^= src[i];
      end
      hist_now.fill_carry = carry;
    end
    r.d_word = d;
    r.end_of_row = w.row_last;
    return r;
  endfunction

  function automatic logic [15:0] pick(input int unsigned hi);
    case ($urandom_range(0, 3))
      0:       return 16'(0);
      1:       return 16'(hi);
      default: return 16'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic bwmf_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return bwmf_pkg::word_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] sel, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    cfg_open = 1'b1;
    @(posedge clk);
    case (sel)
      bwmf_pkg::RegMinterm:   cfg_now.minterm_function = val[7:0];
      bwmf_pkg::RegAShift:    cfg_now.a_shift_amount = val[3:0];
      bwmf_pkg::RegBShift:    cfg_now.b_shift_amount = val[3:0];
      bwmf_pkg::RegDesc:      cfg_now.descending_mode = val[0];
      bwmf_pkg::RegFillMode:  cfg_now.fill_mode = val[1:0];
      bwmf_pkg::RegFillCin:   cfg_now.fill_carry_in = val[0];
      bwmf_pkg::RegFirstMask: cfg_now.first_word_mask = val;
      bwmf_pkg::RegLastMask:  cfg_now.last_word_mask = val;
      default: ;
    endcase
  endtask

  // Leaves tvalid high after the accept; the caller lowers it or offers the next word
  task automatic send_word(input bwmf_pkg::item_t w, input bit pinned,
                           input bwmf_pkg::word_t pinned_d);
    int    gap;
    dest_t r;
    if (cfg_open) begin
      cfg_wr_en <= 1'b0;
      cfg_open = 1'b0;
    end
    gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {w.c_word, w.b_word, w.a_word};
    in_tuser <= {w.row_first, w.blit_start};
    in_tlast <= w.row_last;
    do @(posedge clk); while (!in_tready);
    r = blit_dest(w);
    if (pinned) r.d_word = pinned_d;
    pending_dest.push_back(r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_dest.size() != 0) @(posedge clk);
  endtask

  // Result side: check, then choose ready for the next cycle
  initial begin
    int    stall_left;
    dest_t want;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_dest.size() == 0) begin
          $error("unexpected word: d_word %h end_of_row %b", out_tdata, out_tlast);
          fails++;
        end else begin
          want = pending_dest.pop_front();
          if (out_tdata !== want.d_word) begin
            $error("d_word: expected %h, got %h", want.d_word, out_tdata);
            fails++;
          end
          if (out_tlast !== want.end_of_row) begin
            $error("end_of_row: expected %b, got %b", want.end_of_row, out_tlast);
            fails++;
          end
        end
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    bwmf_pkg::item_t w;
    int    left, len;
    bit    noisy, new_blit;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    in_tlast <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= bwmf_pkg::RegMinterm;
    cfg_data <= '0;
    cfg_now = '0;
    cfg_now.first_word_mask = '1;
    cfg_now.last_word_mask = '1;
    hist_now = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (Plan[i]) begin
      if (Plan[i].kind == RowCfg) begin
        drain();
        write_reg(Plan[i].cfg_sel, Plan[i].value);
      end else begin
        w.a_word = Plan[i].a_word;
        w.b_word = Plan[i].b_word;
        w.c_word = Plan[i].c_word;
        {w.blit_start, w.row_first, w.row_last} = Plan[i].flags;
        send_word(w, Plan[i].kind == RowPinned, Plan[i].value);
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      write_reg(bwmf_pkg::RegMinterm, pick(8'hFF));
      write_reg(bwmf_pkg::RegAShift, pick(15));
      write_reg(bwmf_pkg::RegBShift, pick(15));
      write_reg(bwmf_pkg::RegDesc, pick(1));
      write_reg(bwmf_pkg::RegFillMode, pick(3));
      write_reg(bwmf_pkg::RegFillCin, pick(1));
      write_reg(bwmf_pkg::RegFirstMask, pick(16'hFFFF));
      write_reg(bwmf_pkg::RegLastMask, pick(16'hFFFF));
      // the closing phases run without gaps on either side
      tx_idle_en = (p < PhaseCount - 2) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (p < PhaseCount - 2) && ($urandom_range(0, 3) != 0);
      if (p == 2 || p == 7) hold_req = $urandom_range(40, 80);
      left = PhaseWords;
      while (left > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        noisy = ($urandom_range(0, 7) == 0);
        new_blit = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len && left > 0; k++) begin
          w.a_word = rand_word();
          w.b_word = rand_word();
          w.c_word = rand_word();
          if (noisy) begin
            {w.blit_start, w.row_first, w.row_last} = 3'($urandom_range(0, 7));
          end else begin
            w.blit_start = new_blit && (k == 0);
            w.row_first = (k == 0);
            w.row_last = (k == len - 1);
          end
          send_word(w, 1'b0, '0);
          left--;
        end
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
